/* rtl/iee_pkg.sv */
// ----------------------------------------------------------------------------
// iee_pkg
// Shared types and constants of the infix expression evaluator: value width,
// character codes, operator codes and the controller/datapath link structs.
// ----------------------------------------------------------------------------
`default_nettype none

package iee_pkg;

  localparam int unsigned ValueBits = 32;
  localparam int unsigned CountBits = $clog2(ValueBits);

  // ascii codes with a meaning
  localparam logic [7:0] ChrPlus  = 8'h2B;
  localparam logic [7:0] ChrMinus = 8'h2D;
  localparam logic [7:0] ChrStar  = 8'h2A;
  localparam logic [7:0] ChrSlash = 8'h2F;
  localparam logic [7:0] ChrEqual = 8'h3D;
  localparam logic [7:0] ChrZero  = 8'h30;
  localparam logic [7:0] ChrNine  = 8'h39;

  // operator latched on an operator character
  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_EQ  = 3'd4
  } op_e;

  // pending multiplicative operator, code 3 acts as none
  localparam logic [1:0] PendNone = 2'd0;
  localparam logic [1:0] PendMul  = 2'd1;
  localparam logic [1:0] PendDiv  = 2'd2;

  typedef logic [ValueBits-1:0] value_t;

  // datapath to controller
  typedef struct packed {
    logic       sym_digit;
    logic       sym_op;
    logic       first;
    logic [1:0] pend;
    logic       num_zero;
    logic       div_last;
    logic       res_free;
    op_e        op;
  } iee_stat_t;

  // controller to datapath
  typedef struct packed {
    logic digit;
    logic latch_op;
    logic load_term;
    logic mul;
    logic div_zero;
    logic div_start;
    logic div_step;
    logic div_finish;
    logic post;
    logic emit;
  } iee_cmd_t;

  function automatic value_t magnitude(input value_t v);
    value_t m;
    m = v[ValueBits-1] ? (~v + value_t'(1)) : v;
    return m;
  endfunction

endpackage

`default_nettype wire

/* rtl/iee_if.sv */
// ----------------------------------------------------------------------------
// iee_sym_if / iee_res_if
// Valid/ready channels of the evaluator: one character in, one result out.
// ----------------------------------------------------------------------------
`default_nettype none

interface iee_sym_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;

  modport source (output valid, output symbol, input ready);
  modport sink   (input valid, input symbol, output ready);
endinterface

interface iee_res_if import iee_pkg::*;;
  logic                        valid;
  logic                        ready;
  logic signed [ValueBits-1:0] value;
  logic                        div_zero;

  modport source (output valid, output value, output div_zero, input ready);
  modport sink   (input valid, input value, input div_zero, output ready);
endinterface

`default_nettype wire

/* rtl/iee_ctrl.sv */
// ----------------------------------------------------------------------------
// iee_ctrl
// Sequencer of the evaluator: takes characters, steps the fold of number,
// term and sum, runs the divider and hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module iee_ctrl import iee_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output      logic      in_ready_o,
  input  wire iee_stat_t stat_i,
  output      iee_cmd_t  cmd_o
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_FOLD = 6'b000010,
    ST_DIV  = 6'b000100,
    ST_DFIN = 6'b001000,
    ST_POST = 6'b010000,
    ST_EMIT = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (stat_i.sym_digit) begin
            cmd_o.digit = 1'b1;
          end else if (stat_i.sym_op) begin
            cmd_o.latch_op = 1'b1;
            state_d        = ST_FOLD;
          end
        end
      end
      ST_FOLD: begin
        if (stat_i.first || !(stat_i.pend == PendMul || stat_i.pend == PendDiv)) begin
          cmd_o.load_term = 1'b1;
          state_d         = ST_POST;
        end else if (stat_i.pend == PendMul) begin
          cmd_o.mul = 1'b1;
          state_d   = ST_POST;
        end else if (stat_i.num_zero) begin
          cmd_o.div_zero = 1'b1;
          state_d        = ST_POST;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          state_d = ST_DFIN;
        end
      end
      ST_DFIN: begin
        cmd_o.div_finish = 1'b1;
        state_d          = ST_POST;
      end
      ST_POST: begin
        cmd_o.post = 1'b1;
        if (stat_i.op == OP_EQ) begin
          state_d = ST_EMIT;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (stat_i.res_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/iee_dpath.sv */
// ----------------------------------------------------------------------------
// iee_dpath
// Evaluator datapath: number, term and sum registers, multiplier, a one bit
// per cycle restoring divider and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module iee_dpath import iee_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic [7:0] symbol_i,
  input  wire iee_cmd_t   cmd_i,
  output      iee_stat_t  stat_o,
  input  wire logic       res_ready_i,
  output      logic       res_valid_o,
  output      value_t     res_value_o,
  output      logic       res_div_zero_o
);

  value_t         sum_q, term_q, num_q;
  logic           add_sign_q, first_q, derr_q;
  logic [1:0]     pend_q;
  op_e            op_q;
  logic           res_valid_q;
  value_t         res_value_q;
  logic           res_derr_q;

  // divider working registers
  value_t         rem_q, quo_q, dvs_q;
  logic           neg_q;
  logic [CountBits-1:0] cnt_q;

  logic           sym_digit;
  op_e            sym_code;
  logic           sym_op;
  value_t         digit_val;
  value_t         prod;
  logic [ValueBits:0]     rem_shift;
  logic           rem_ge;

  // character decode
  always_comb begin
    sym_digit = (symbol_i >= ChrZero) && (symbol_i <= ChrNine);
    sym_op    = 1'b1;
    sym_code  = OP_ADD;
    case (symbol_i)
      ChrPlus:  sym_code = OP_ADD;
      ChrMinus: sym_code = OP_SUB;
      ChrStar:  sym_code = OP_MUL;
      ChrSlash: sym_code = OP_DIV;
      ChrEqual: sym_code = OP_EQ;
      default:  sym_op   = 1'b0;
    endcase
  end

  assign digit_val = {{(ValueBits-4){1'b0}}, symbol_i[3:0]};
  // low half of the product is all that survives the wrap
  assign prod      = term_q * num_q;

  // one restoring step
  assign rem_shift = {rem_q, quo_q[ValueBits-1]};
  assign rem_ge    = rem_shift >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= '0;
      term_q      <= '0;
      num_q       <= '0;
      add_sign_q  <= 1'b0;
      pend_q      <= PendNone;
      first_q     <= 1'b1;
      derr_q      <= 1'b0;
      op_q        <= OP_ADD;
      res_valid_q <= 1'b0;
    end else begin
      if (cmd_i.digit) begin
        num_q <= (num_q << 3) + (num_q << 1) + digit_val;
      end
      if (cmd_i.latch_op) begin
        op_q <= sym_code;
      end
      if (cmd_i.load_term) begin
        term_q <= num_q;
      end
      if (cmd_i.mul) begin
        term_q <= prod;
      end
      if (cmd_i.div_zero) begin
        term_q <= '0;
        derr_q <= 1'b1;
      end
      if (cmd_i.load_term || cmd_i.mul || cmd_i.div_zero || cmd_i.div_start) begin
        num_q <= '0;
      end
      if (cmd_i.div_finish) begin
        term_q <= neg_q ? (~quo_q + value_t'(1)) : quo_q;
      end
      if (cmd_i.post) begin
        if (op_q == OP_MUL || op_q == OP_DIV) begin
          pend_q  <= (op_q == OP_MUL) ? PendMul : PendDiv;
          first_q <= 1'b0;
        end else begin
          sum_q      <= add_sign_q ? (sum_q - term_q) : (sum_q + term_q);
          term_q     <= '0;
          pend_q     <= PendNone;
          first_q    <= 1'b1;
          add_sign_q <= (op_q == OP_SUB);
        end
      end
      // result register: filled on emit, drained by the sink
      if (cmd_i.emit) begin
        res_valid_q <= 1'b1;
        sum_q       <= '0;
        term_q      <= '0;
        num_q       <= '0;
        add_sign_q  <= 1'b0;
        pend_q      <= PendNone;
        first_q     <= 1'b1;
        derr_q      <= 1'b0;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      res_value_q <= sum_q;
      res_derr_q  <= derr_q;
    end
    if (cmd_i.div_start) begin
      rem_q <= '0;
      quo_q <= magnitude(term_q);
      dvs_q <= magnitude(num_q);
      neg_q <= term_q[ValueBits-1] ^ num_q[ValueBits-1];
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= rem_ge ? value_t'(rem_shift - {1'b0, dvs_q}) : rem_shift[ValueBits-1:0];
      quo_q <= {quo_q[ValueBits-2:0], rem_ge};
      cnt_q <= cnt_q + 1'b1;
    end
  end

  always_comb begin
    stat_o.sym_digit = sym_digit;
    stat_o.sym_op    = sym_op;
    stat_o.first     = first_q;
    stat_o.pend      = pend_q;
    stat_o.num_zero  = (num_q == '0);
    stat_o.div_last  = (cnt_q == CountBits'(ValueBits - 1));
    stat_o.res_free  = !res_valid_q || res_ready_i;
    stat_o.op        = op_q;
  end

  assign res_valid_o    = res_valid_q;
  assign res_value_o    = res_value_q;
  assign res_div_zero_o = res_derr_q;

endmodule

`default_nettype wire

/* rtl/infix_expression_evaluator_unit.sv */
// ----------------------------------------------------------------------------
// infix_expression_evaluator_unit
// Character-serial evaluator of integer expressions in + - * / ending in '='.
// ----------------------------------------------------------------------------
// Feed one ASCII character per request on sym_i. Digits build a decimal
// number, '*' and '/' bind tighter than '+' and '-', equal levels go left to
// right, and '=' delivers one request on res_o with the 32-bit wrapped value
// and a flag that is set when the expression divided by zero; the state is
// then cleared for the next expression. Other characters are taken and
// ignored. A digit or an ignored character is taken without a stall. An
// operator takes three steps (accept, fold into the term, fold into the sum),
// a multiply is done within the term fold, and a divide by a nonzero number
// adds the restoring divider (32 steps of one quotient bit each and a step
// to fix the sign). '=' then loads the result into a one-deep output
// register once it is free; new characters are taken while a result waits
// there, and only a second '=' holds the input until the first is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module infix_expression_evaluator_unit import iee_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  iee_sym_if.sink   sym_i,
  iee_res_if.source res_o
);

  // command and status link between sequencer and datapath
  iee_cmd_t  cmd;
  iee_stat_t stat;
  value_t    res_value;

  // sequencer: handshake on the input side, steps the fold and the divider
  iee_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (sym_i.valid),
    .in_ready_o (sym_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // datapath: arithmetic state and the output register
  iee_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .symbol_i       (sym_i.symbol),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .res_ready_i    (res_o.ready),
    .res_valid_o    (res_o.valid),
    .res_value_o    (res_value),
    .res_div_zero_o (res_o.div_zero)
  );

  // two's complement result as a signed field
  assign res_o.value = $signed(res_value);

endmodule

`default_nettype wire
